// ===== hdl/gde_pkg.sv =====
package gde_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // register and field widths
  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int THR_W        = 8;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  // register reset values
  localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST    = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST   = HEIGHT_REG_W'(480);
  localparam logic [THR_W-1:0]        EDGE_THRESHOLD_RST = THR_W'(20);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // 3x3 neighbourhood, entry 3*row+col, row 0 at the top
  typedef logic [8:0][PIX_W-1:0] win_t;

  // position of one item and what it will emit
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] res_row;
    logic [COL_W-1:0] res_col;
    logic             emit;
    logic             last;
  } pos_t;

endpackage

// ===== hdl/gde_in_if.sv =====
interface gde_in_if;
  logic            valid;
  logic            ready;
  gde_pkg::pixel_t pixel;
  logic            frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== hdl/gde_out_if.sv =====
interface gde_out_if;
  logic                      valid;
  logic                      ready;
  logic                      edge_res;
  logic [gde_pkg::ROW_W-1:0] out_row;
  logic [gde_pkg::COL_W-1:0] out_col;
  logic                      frame_last;

  modport source (output valid, output edge_res, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink (input valid, input edge_res, input out_row, input out_col,
                input frame_last, output ready);
endinterface

// ===== hdl/gde_ram.sv =====
module gde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read returning the old contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/gde_pos.sv =====
module gde_pos (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic                               frame_start,
  input  logic [gde_pkg::WIDTH_REG_W-1:0]    image_width,
  input  logic [gde_pkg::HEIGHT_REG_W-1:0]   image_height,
  output gde_pkg::pos_t                      pos
);

  localparam int CW = gde_pkg::COL_W;
  localparam int RW = gde_pkg::ROW_W;
  localparam int WW = gde_pkg::WIDTH_REG_W;
  localparam int HW = gde_pkg::HEIGHT_REG_W;

  logic [CW-1:0] col_count_r, col_count_nxt;
  logic [RW-1:0] row_count_r, row_count_nxt;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [CW-1:0] c0, c;
  logic [RW-1:0] r0, r;
  logic          col_last, row_last;

  // working frame size, clamped to the supported range
  always_comb begin
    if (image_width < WW'(3)) begin
      w = WW'(3);
    end else if (image_width > WW'(gde_pkg::MAX_WIDTH)) begin
      w = WW'(gde_pkg::MAX_WIDTH);
    end else begin
      w = image_width;
    end
    if (image_height < HW'(3)) begin
      h = HW'(3);
    end else if (image_height > HW'(gde_pkg::MAX_HEIGHT)) begin
      h = HW'(gde_pkg::MAX_HEIGHT);
    end else begin
      h = image_height;
    end
  end

  // position of this item: frame start, then wrap past a shrunken size
  always_comb begin
    c0 = frame_start ? '0 : col_count_r;
    r0 = frame_start ? '0 : row_count_r;
    c  = (WW'(c0) >= w) ? '0 : c0;
    r  = (HW'(r0) >= h) ? '0 : r0;
    col_last = ((WW'(c) + WW'(1)) == w);
    row_last = ((HW'(r) + HW'(1)) == h);
  end

  // next position
  always_comb begin
    if (col_last) begin
      col_count_nxt = '0;
      row_count_nxt = row_last ? '0 : r + RW'(1);
    end else begin
      col_count_nxt = c + CW'(1);
      row_count_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else if (advance) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // result tag for the window centre
  always_comb begin
    pos.col     = c;
    pos.res_row = r - RW'(1);
    pos.res_col = c - CW'(1);
    pos.emit    = (r >= RW'(2)) && (c >= CW'(2));
    pos.last    = row_last && col_last;
  end

endmodule

// ===== hdl/gde_kernel.sv =====
module gde_kernel (
  input  gde_pkg::win_t                 win,
  input  logic [gde_pkg::THR_W-1:0]     threshold,
  output logic                          edge_res
);

  localparam int PW = gde_pkg::PIX_W;
  localparam int GW = PW + 3;
  localparam int AW = PW + 2;
  localparam int SW = 2 * AW;
  localparam int TW = SW + 2;

  logic signed [GW-1:0] sp [9];
  logic signed [GW-1:0] fx, fy;
  logic [AW-1:0]        ax, ay;
  logic [SW-1:0]        sqx, sqy;
  logic [TW-1:0]        sqx3, sqy3;
  logic                 take_x, take_y;
  logic [3:0]           ia;
  gde_pkg::pixel_t      pa, pb, diff;

  // gradients of the window
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      sp[k] = signed'(GW'(win[k]));
    end
    fy = (sp[0] - sp[6]) + ((sp[1] - sp[7]) <<< 1) + (sp[2] - sp[8]);
    fx = (sp[2] - sp[0]) + ((sp[5] - sp[3]) <<< 1) + (sp[8] - sp[6]);
  end

  // direction test: step along an axis when 3*g^2 >= other^2
  always_comb begin
    ax     = fx[GW-1] ? AW'(-fx) : AW'(fx);
    ay     = fy[GW-1] ? AW'(-fy) : AW'(fy);
    sqx    = ax * ax;
    sqy    = ay * ay;
    sqx3   = {1'b0, sqx, 1'b0} + TW'(sqx);
    sqy3   = {1'b0, sqy, 1'b0} + TW'(sqy);
    take_x = (sqx3 >= TW'(sqy)) && (fx != '0);
    take_y = (sqy3 >= TW'(sqx)) && (fy != '0);
  end

  // neighbour at +(dy,dx); the opposite one mirrors through the centre
  always_comb begin
    ia = 4'd4;
    if (take_y) begin
      ia = fy[GW-1] ? ia - 4'd3 : ia + 4'd3;
    end
    if (take_x) begin
      ia = fx[GW-1] ? ia - 4'd1 : ia + 4'd1;
    end
    pa       = win[ia];
    pb       = win[4'd8 - ia];
    diff     = (pa > pb) ? pa - pb : pb - pa;
    edge_res = ((fx != '0) || (fy != '0)) && (diff > threshold);
  end

endmodule

// ===== hdl/gradient_direction_edge_detect.sv =====
// 3x3 gradient-direction edge detector for a raster stream of grey pixels.
// in_ch carries one pixel per item with frame_start marking row 0, column 0;
// out_ch carries one result for each interior pixel: edge flag, centre row
// and column, and frame_last on the final result of the frame. Border pixels
// give no result. Both channels move an item when valid and ready are high.
// The cfg port writes image_width, image_height and edge_threshold by index;
// write only while no item is in flight.
// Throughput is one item per cycle unless a result waits on a full result
// register. Stage one registers the line store read and position tag; the
// window shift, gradient and neighbour compare then feed the result
// register.
// The result register parts the two sides: while out_ch stalls, pixels that
// give no result keep flowing, and in_ready drops only when a result is
// waiting behind a full result register.
// Reset (synchronous, rst_n low) clears the position counters, the window,
// the pipeline valids and restores the register defaults (640, 480, 20).
// The line stores are not cleared; the first two rows of a frame fill them.
module gradient_direction_edge_detect (
  input  logic                               clk,
  input  logic                               rst_n,
  gde_in_if.sink                             in_ch,
  gde_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [gde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gde_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW = gde_pkg::COL_W;
  localparam int RW = gde_pkg::ROW_W;

  logic [gde_pkg::WIDTH_REG_W-1:0]  image_width_r;
  logic [gde_pkg::HEIGHT_REG_W-1:0] image_height_r;
  logic [gde_pkg::THR_W-1:0]        edge_threshold_r;

  gde_pkg::pos_t   pos;
  logic            accept;
  logic            s1_adv;
  logic            out_free;

  logic            s1_valid_r;
  gde_pkg::pos_t   s1_pos_r;
  gde_pkg::pixel_t s1_px_r;
  logic            s1_byp_r;
  gde_pkg::pixel_t s1_byp_up_r;
  gde_pkg::pixel_t s1_byp_mid_r;

  gde_pkg::pixel_t ram_up, ram_mid;
  gde_pkg::pixel_t up_eff, mid_eff;

  gde_pkg::win_t   win_r, win_nxt;
  logic            edge_nxt;

  logic            out_valid_r;
  logic            edge_res_r;
  logic [RW-1:0]   out_row_r;
  logic [CW-1:0]   out_col_r;
  logic            frame_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= gde_pkg::IMAGE_WIDTH_RST;
      image_height_r   <= gde_pkg::IMAGE_HEIGHT_RST;
      edge_threshold_r <= gde_pkg::EDGE_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (gde_pkg::cfg_idx_t'(cfg_index))
        gde_pkg::CFG_IMAGE_WIDTH: begin
          image_width_r <= cfg_wdata[gde_pkg::WIDTH_REG_W-1:0];
        end
        gde_pkg::CFG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_wdata[gde_pkg::HEIGHT_REG_W-1:0];
        end
        gde_pkg::CFG_EDGE_THRESHOLD: begin
          edge_threshold_r <= cfg_wdata[gde_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // handshake: stage one leaves unless its result meets a full result register
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && (!s1_pos_r.emit || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign accept       = in_ch.valid && in_ch.ready;

  // position counters
  gde_pos u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .frame_start  (in_ch.frame_start),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .pos          (pos)
  );

  // line stores: read on accept, written back as stage one leaves
  gde_ram #(.WIDTH(gde_pkg::PIX_W), .DEPTH(gde_pkg::MAX_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_pos_r.col),
    .wr_data (mid_eff),
    .rd_en   (accept),
    .rd_addr (pos.col),
    .rd_data (ram_up)
  );

  gde_ram #(.WIDTH(gde_pkg::PIX_W), .DEPTH(gde_pkg::MAX_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_pos_r.col),
    .wr_data (s1_px_r),
    .rd_en   (accept),
    .rd_addr (pos.col),
    .rd_data (ram_mid)
  );

  // forward a write that lands on the column being read in the same cycle
  assign up_eff  = s1_byp_r ? s1_byp_up_r  : ram_up;
  assign mid_eff = s1_byp_r ? s1_byp_mid_r : ram_mid;

  // stage one: pixel, position tag and line store data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r     <= pos;
      s1_px_r      <= in_ch.pixel;
      s1_byp_r     <= s1_adv && (s1_pos_r.col == pos.col);
      s1_byp_up_r  <= mid_eff;
      s1_byp_mid_r <= s1_px_r;
    end
  end

  // window shift: columns move left, new column from the stores and pixel
  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up_eff;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_eff;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // gradient, direction and neighbour compare on the new window
  gde_kernel u_kernel (
    .win       (win_nxt),
    .threshold (edge_threshold_r),
    .edge_res  (edge_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_pos_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pos_r.emit) begin
      edge_res_r   <= edge_nxt;
      out_row_r    <= s1_pos_r.res_row;
      out_col_r    <= s1_pos_r.res_col;
      frame_last_r <= s1_pos_r.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_res   = edge_res_r;
  assign out_ch.out_row    = out_row_r;
  assign out_ch.out_col    = out_col_r;
  assign out_ch.frame_last = frame_last_r;

endmodule

// ===== hdl/gde_checker.sv =====
module gde_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gde_pkg::ROW_W-1:0] out_row,
  input logic [gde_pkg::COL_W-1:0] out_col,
  input logic                      frame_last
);

  // no result survives a reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(frame_last))
    else $error("stalled result changed");

  // only interior centres are reported
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row != '0) && (out_col != '0))
    else $error("border centre reported");

  // an empty result register never holds back the input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with free result register");

endmodule

bind gradient_direction_edge_detect gde_checker u_gde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_row    (out_ch.out_row),
  .out_col    (out_ch.out_col),
  .frame_last (out_ch.frame_last)
);

// ===== tb/tb_gradient_direction_edge_detect.sv =====
module tb_gradient_direction_edge_detect;

  localparam int ROW_W        = gde_pkg::ROW_W;
  localparam int COL_W        = gde_pkg::COL_W;
  localparam int CFG_IDX_W    = gde_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = gde_pkg::CFG_DATA_W;
  localparam int MAX_WIDTH    = gde_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT   = gde_pkg::MAX_HEIGHT;
  localparam int WIDTH_REG_W  = gde_pkg::WIDTH_REG_W;
  localparam int HEIGHT_REG_W = gde_pkg::HEIGHT_REG_W;
  localparam int THR_W        = gde_pkg::THR_W;

  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 40;
  localparam int CLAMP_ITEMS   = 60;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum int {STYLE_UNIFORM, STYLE_BINARY, STYLE_SMOOTH, STYLE_RAMP} pix_style_t;

  typedef struct packed {
    logic             edge_res;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } edge_result_t;

  typedef struct packed {
    gde_pkg::pixel_t px;
    logic            fs;
    logic            typed;
    edge_result_t    res;
  } stim_row_t;

  localparam edge_result_t NO_RESULT   = '0;
  localparam edge_result_t FLAT_CENTRE = '{1'b0, ROW_W'(1), COL_W'(1), 1'b1};
  localparam edge_result_t EDGE_CENTRE = '{1'b1, ROW_W'(1), COL_W'(1), 1'b1};

  // directed items on a 3x3 frame, threshold 20
  localparam stim_row_t DIRECTED [28] = '{
    // flat frame: zero gradient, no edge
    '{8'd0, 1'b1, 1'b0, NO_RESULT}, '{8'd0, 1'b0, 1'b0, NO_RESULT},
    '{8'd0, 1'b0, 1'b0, NO_RESULT}, '{8'd0, 1'b0, 1'b0, NO_RESULT},
    '{8'd0, 1'b0, 1'b0, NO_RESULT}, '{8'd0, 1'b0, 1'b0, NO_RESULT},
    '{8'd0, 1'b0, 1'b0, NO_RESULT}, '{8'd0, 1'b0, 1'b0, NO_RESULT},
    '{8'd0, 1'b0, 1'b1, FLAT_CENTRE},
    // frame cut short after one pixel
    '{8'd255, 1'b1, 1'b0, NO_RESULT},
    // bright top row over black: vertical step, full swing
    '{8'd255, 1'b1, 1'b0, NO_RESULT}, '{8'd255, 1'b0, 1'b0, NO_RESULT},
    '{8'd255, 1'b0, 1'b0, NO_RESULT}, '{8'd0, 1'b0, 1'b0, NO_RESULT},
    '{8'd0, 1'b0, 1'b0, NO_RESULT}, '{8'd0, 1'b0, 1'b0, NO_RESULT},
    '{8'd0, 1'b0, 1'b0, NO_RESULT}, '{8'd0, 1'b0, 1'b0, NO_RESULT},
    '{8'd0, 1'b0, 1'b1, EDGE_CENTRE},
    // next frame follows by position wrap alone
    '{8'd10, 1'b0, 1'b0, NO_RESULT}, '{8'd200, 1'b0, 1'b0, NO_RESULT},
    '{8'd30, 1'b0, 1'b0, NO_RESULT}, '{8'd0, 1'b0, 1'b0, NO_RESULT},
    '{8'd128, 1'b0, 1'b0, NO_RESULT}, '{8'd255, 1'b0, 1'b0, NO_RESULT},
    '{8'd90, 1'b0, 1'b0, NO_RESULT}, '{8'd1, 1'b0, 1'b0, NO_RESULT},
    '{8'd254, 1'b0, 1'b0, NO_RESULT}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  calm;

  gde_in_if  in_ch ();
  gde_out_if out_ch ();

  gradient_direction_edge_detect u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block: line stores, window, position, registers
  bit [7:0] row_above [MAX_WIDTH];
  bit [7:0] row_centre [MAX_WIDTH];
  bit [7:0] nb [9];
  int       pos_row;
  int       pos_col;
  int       reg_width  = 640;
  int       reg_height = 480;
  int       reg_thresh = 20;

  edge_result_t pending_q [$];

  int cycle_no        = 0;
  int idle_cycles     = 0;
  int mismatches      = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int edges_seen      = 0;
  int settings_run    = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one long stretch where neither side idles
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end
  assign calm = (cycle_no >= 400) && (cycle_no < 900);

  // result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = calm || ($urandom_range(99) >= 9);
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("tb: mismatch: %s", msg);
  endtask

  function automatic int clamp_dim(int v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // step along one axis of the gradient direction
  function automatic int dir_step(int g, int other);
    if (3 * g * g >= other * other) return (g > 0) ? 1 : ((g < 0) ? -1 : 0);
    return 0;
  endfunction

  // advance the shadow by one pixel and work out its result, if any
  task automatic predict_pixel(input gde_pkg::pixel_t px, input logic fs,
                               output bit has_res, output edge_result_t res);
    int       w, h, r, c, fx, fy, dx, dy, a, b, diff;
    bit [7:0] up, mid;
    w = clamp_dim(reg_width, MAX_WIDTH);
    h = clamp_dim(reg_height, MAX_HEIGHT);
    has_res = 1'b0;
    res = NO_RESULT;
    if (fs) begin
      pos_row = 0;
      pos_col = 0;
    end
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= h) pos_row = 0;
    r = pos_row;
    c = pos_col;
    up = row_above[c];
    mid = row_centre[c];
    row_above[c] = mid;
    row_centre[c] = px;
    for (int k = 0; k < 3; k++) begin
      nb[3*k]   = nb[3*k+1];
      nb[3*k+1] = nb[3*k+2];
    end
    nb[2] = up;
    nb[5] = mid;
    nb[8] = px;
    if (r >= 2 && c >= 2) begin
      fy = (int'(nb[0]) - int'(nb[6])) + 2 * (int'(nb[1]) - int'(nb[7]))
         + (int'(nb[2]) - int'(nb[8]));
      fx = (int'(nb[2]) - int'(nb[0])) + 2 * (int'(nb[5]) - int'(nb[3]))
         + (int'(nb[8]) - int'(nb[6]));
      if (fx != 0 || fy != 0) begin
        dx = dir_step(fx, fy);
        dy = dir_step(fy, fx);
        a = nb[(1 + dy) * 3 + (1 + dx)];
        b = nb[(1 - dy) * 3 + (1 - dx)];
        diff = (a > b) ? (a - b) : (b - a);
        res.edge_res = (diff > reg_thresh);
      end
      res.row = ROW_W'(r - 1);
      res.col = COL_W'(c - 1);
      res.last = (r == h - 1) && (c == w - 1);
      has_res = 1'b1;
    end
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endtask

  // raise a register write for one cycle, entered and left at a falling edge
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DATA_W'(data);
    case (idx)
      gde_pkg::CFG_IMAGE_WIDTH:    reg_width = int'(cfg_wdata[WIDTH_REG_W-1:0]);
      gde_pkg::CFG_IMAGE_HEIGHT:   reg_height = int'(cfg_wdata[HEIGHT_REG_W-1:0]);
      gde_pkg::CFG_EDGE_THRESHOLD: reg_thresh = int'(cfg_wdata[THR_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic program_regs(input bit wr_w, input int w, input bit wr_h, input int h,
                              input bit wr_t, input int t, input bit wr_spare);
    if (wr_w) set_reg(gde_pkg::CFG_IMAGE_WIDTH, w);
    if (wr_h) set_reg(gde_pkg::CFG_IMAGE_HEIGHT, h);
    if (wr_t) set_reg(gde_pkg::CFG_EDGE_THRESHOLD, t);
    if (wr_spare) set_reg(CFG_UNUSED_IDX, $urandom_range(8191));
    cfg_we = 1'b0;
    settings_run++;
  endtask

  // offer one item, wait for the handshake, record what it should give
  task automatic send_pixel(input gde_pkg::pixel_t px, input logic fs, input logic typed,
                            input edge_result_t typed_res);
    bit           has_res;
    edge_result_t res;
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.pixel = px;
    in_ch.frame_start = fs;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_pixel(px, fs, has_res, res);
    if (typed) pending_q.push_back(typed_res);
    else if (has_res) pending_q.push_back(res);
    pixels_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every result is in and the pipeline has emptied
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // stream of frames with random content, optionally with stray frame starts
  task automatic run_frames(input int n_items, input pix_style_t style,
                            input bit force_start, input bit mid_pause, input bit noisy);
    int              base, spread, v;
    gde_pkg::pixel_t px;
    logic            fs;
    base = $urandom_range(255);
    spread = $urandom_range(40);
    for (int i = 0; i < n_items; i++) begin
      case (style)
        STYLE_UNIFORM: px = gde_pkg::pixel_t'($urandom_range(255));
        STYLE_BINARY:  px = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        STYLE_SMOOTH: begin
          v = base + int'($urandom_range(2 * spread)) - spread;
          px = (v < 0) ? 8'h00 : ((v > 255) ? 8'hFF : gde_pkg::pixel_t'(v));
        end
        default: px = gde_pkg::pixel_t'(pos_col * (base % 16) + pos_row * (spread % 16));
      endcase
      fs = (i == 0 && force_start)
        || (pos_row == 0 && pos_col == 0 && $urandom_range(3) != 0)
        || (noisy && $urandom_range(99) < 2);
      if (mid_pause && i == n_items / 2) drain_results();
      send_pixel(px, fs, 1'b0, NO_RESULT);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    edge_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result at row %0d col %0d with nothing expected",
                                  out_ch.out_row, out_ch.out_col));
      end else begin
        want = pending_q.pop_front();
        results_checked++;
        if (out_ch.edge_res === 1'b1) edges_seen++;
        if (out_ch.edge_res !== want.edge_res)
          report_mismatch($sformatf("edge_res at row %0d col %0d: got %0b want %0b",
                                    want.row, want.col, out_ch.edge_res, want.edge_res));
        if (out_ch.out_row !== want.row)
          report_mismatch($sformatf("out_row: got %0d want %0d", out_ch.out_row, want.row));
        if (out_ch.out_col !== want.col)
          report_mismatch($sformatf("out_col: got %0d want %0d", out_ch.out_col, want.col));
        if (out_ch.frame_last !== want.last)
          report_mismatch($sformatf("frame_last at row %0d col %0d: got %0b want %0b",
                                    want.row, want.col, out_ch.frame_last, want.last));
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: timeout after %0d cycles with no item accepted", idle_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    int  old_w, w, h, t, n, random_sent;
    random_sent = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pixel = '0;
    in_ch.frame_start = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed items on the smallest frame
    program_regs(1'b1, 3, 1'b1, 3, 1'b1, 20, 1'b0);
    for (int i = 0; i < $size(DIRECTED); i++)
      send_pixel(DIRECTED[i].px, DIRECTED[i].fs, DIRECTED[i].typed, DIRECTED[i].res);
    drain_results();

    // sizes below range clamp to 3, top threshold never marks an edge
    program_regs(1'b1, 1, 1'b1, 2, 1'b1, 255, 1'b1);
    run_frames(27, STYLE_BINARY, 1'b1, 1'b0, 1'b0);
    drain_results();

    // width above range clamps to the widest row: the top row runs on unbroken
    program_regs(1'b1, 2047, 1'b1, 3, 1'b1, 0, 1'b0);
    run_frames(CLAMP_ITEMS, STYLE_UNIFORM, 1'b1, 1'b0, 1'b0);
    drain_results();

    // height above range clamps to the tallest frame, on the narrowest width
    program_regs(1'b1, 0, 1'b1, 8191, 1'b1, 40, 1'b0);
    run_frames(CLAMP_ITEMS, STYLE_UNIFORM, 1'b1, 1'b0, 1'b0);
    drain_results();

    // random settings, each followed by a burst of frames
    while (random_sent < RANDOM_ITEMS) begin
      old_w = clamp_dim(reg_width, MAX_WIDTH);
      case ($urandom_range(7))
        0:       w = $urandom_range(2);
        1:       w = $urandom_range(40, 13);
        default: w = $urandom_range(12, 3);
      endcase
      h = ($urandom_range(5) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
      case ($urandom_range(5))
        0:       t = 0;
        1:       t = 255;
        2:       t = $urandom_range(255);
        default: t = $urandom_range(60);
      endcase
      program_regs($urandom_range(2) != 0, w, $urandom_range(2) != 0, h,
                   $urandom_range(2) != 0, t, $urandom_range(9) == 0);
      n = $urandom_range(150, 30);
      // a wider row would read line store columns this frame never wrote
      run_frames(n, pix_style_t'($urandom_range(3)),
                 clamp_dim(reg_width, MAX_WIDTH) > old_w || $urandom_range(3) != 0,
                 $urandom_range(2) == 0, 1'b1);
      random_sent += n;
      drain_results();
    end

    // wind down
    in_ch.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
    $display("tb: %0d pixels over %0d register settings, %0d results checked, %0d edges",
             pixels_sent, settings_run, results_checked, edges_seen);
    $display("tb: frames from 3x3 up to 40 wide and 8 high, sizes clamped from both sides");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
